FILE: rtl/svpwm_pkg.sv
`default_nettype none
package svpwm_pkg;

  // configuration register indexes
  localparam logic [1:0] REG_AMPLITUDE  = 2'd0;
  localparam logic [1:0] REG_ANGLE_STEP = 2'd1;
  localparam logic [1:0] REG_PWM_PERIOD = 2'd2;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 16;

  // quarter-wave lookup
  localparam int QUARTER_W = 15;
  localparam logic [QUARTER_W-1:0] QUARTER_TURN = 15'd16384;
  localparam logic [15:0] Q15_MAX = 16'd32767;

  // shared multiplier widths
  localparam int MUL_A_W = 19;
  localparam int MUL_B_W = 17;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;

  // sqrt(3)/2 in q15 and rounding bias
  localparam logic signed [MUL_A_W-1:0] SQRT3_HALF_Q15 = 19'sd28378;
  localparam logic signed [PROD_W-1:0]  ROUND_BIAS     = 36'sd16384;

  typedef logic signed [MUL_A_W-1:0] mul_a_t;
  typedef logic signed [MUL_B_W-1:0] mul_b_t;
  typedef logic signed [PROD_W-1:0]  prod_t;

endpackage
`default_nettype wire

FILE: rtl/svpwm_tick_if.sv
`default_nettype none
interface svpwm_tick_if;
  logic valid;
  logic ready;
  logic advance;

  modport source (output valid, output advance, input ready);
  modport sink (input valid, input advance, output ready);
endinterface
`default_nettype wire

FILE: rtl/svpwm_duty_if.sv
`default_nettype none
interface svpwm_duty_if;
  logic        valid;
  logic        ready;
  logic [15:0] duty_u;
  logic [15:0] duty_v;
  logic [15:0] duty_w;
  logic [15:0] angle_now;

  modport source (output valid, output duty_u, output duty_v, output duty_w,
                  output angle_now, input ready);
  modport sink (input valid, input duty_u, input duty_v, input duty_w,
                input angle_now, output ready);
endinterface
`default_nettype wire

FILE: rtl/svpwm_mul.sv
`default_nettype none
module svpwm_mul (
  input  wire                  clk,
  input  svpwm_pkg::mul_a_t    a,
  input  svpwm_pkg::mul_b_t    b,
  output svpwm_pkg::prod_t     prod
);

  // registered signed product
  always_ff @(posedge clk) begin
    prod <= svpwm_pkg::PROD_W'(a) * svpwm_pkg::PROD_W'(b);
  end

endmodule
`default_nettype wire

FILE: rtl/svpwm_sine_rom.sv
`default_nettype none
module svpwm_sine_rom #(
  parameter int SINE_TABLE_DEPTH = 256
) (
  input  wire                                clk,
  input  wire [svpwm_pkg::QUARTER_W-1:0]     quarter,
  output logic [15:0]                        mag
);

  localparam int IDX_W   = $clog2(SINE_TABLE_DEPTH);
  localparam int SCALE_W = svpwm_pkg::QUARTER_W + IDX_W + 1;

  // odd taylor series in q30, entry scaled to q15 with rounding
  function automatic logic [15:0] sine_entry(input int unsigned idx);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned t;
    longint unsigned s;
    x  = (longint'(idx) * 64'd1686629713) / SINE_TABLE_DEPTH;
    x2 = (x * x) >> 30;
    t  = 64'd1073741824;
    t  = t - ((x2 * t) >> 30) / 64'd110;
    t  = t - ((x2 * t) >> 30) / 64'd72;
    t  = t - ((x2 * t) >> 30) / 64'd42;
    t  = t - ((x2 * t) >> 30) / 64'd20;
    t  = t - ((x2 * t) >> 30) / 64'd6;
    s  = (x * t) >> 30;
    return 16'((s * 64'd32767 + 64'd536870912) >> 30);
  endfunction

  logic [15:0]          sine_rom [SINE_TABLE_DEPTH];
  logic [SCALE_W-1:0]   scaled;
  logic [IDX_W-1:0]     idx;
  logic                 full_scale;

  // constant quarter-wave contents
  for (genvar i = 0; i < SINE_TABLE_DEPTH; i++) begin : g_rom
    localparam logic [15:0] ENTRY = sine_entry(i);
    assign sine_rom[i] = ENTRY;
  end

  // index = quarter * depth / 16384
  assign scaled     = SCALE_W'(quarter) * SCALE_W'(SINE_TABLE_DEPTH);
  assign idx        = scaled[svpwm_pkg::QUARTER_W-1 +: IDX_W];
  assign full_scale = (quarter >= svpwm_pkg::QUARTER_TURN);

  // registered read
  always_ff @(posedge clk) begin
    if (full_scale) begin
      mag <= svpwm_pkg::Q15_MAX;
    end else begin
      mag <= sine_rom[idx];
    end
  end

endmodule
`default_nettype wire

FILE: rtl/open_loop_svpwm_generator_top.sv
// Open-loop space-vector PWM generator with min-max common-mode injection.
// tick (sink): one beat per PWM period; advance=1 steps the phase by
// angle_step before computing, advance=0 recomputes at the current phase.
// duty (source): one beat per tick beat with three compare counts in
// 0..pwm_period and the 16-bit angle they were computed at.
// Config: cfg_we/cfg_index/cfg_data write amplitude (0), angle_step (1)
// and pwm_period (2); write only while no tick is in flight.
// A sequencer walks each tick through the states SIN, COS, MCOS, MSIN, MB,
// VBC, SUM, D0, D1, D2, D3 and OUT, using one quarter-wave ROM read port and
// one shared 19x17 multiplier; tick.ready is high only while the sequencer
// is idle, so no new tick is taken before the last one is through.
// The result sits in an output register, so the next tick is accepted while
// a result waits; if the receiver still holds off when the following result
// is ready, the sequencer waits and takes no new tick.
// Reset: phase goes to zero, registers to amplitude 1638, angle_step 104,
// pwm_period 1000, no result pending. The sine table is constant logic.
`default_nettype none
module open_loop_svpwm_generator_top #(
  parameter int SINE_TABLE_DEPTH = 256,
  parameter int PHASE_BITS       = 16
) (
  input  wire                                 clk,
  input  wire                                 rst,
  input  wire                                 cfg_we,
  input  wire [svpwm_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  wire [svpwm_pkg::CFG_DATA_W-1:0]     cfg_data,
  svpwm_tick_if.sink                          tick,
  svpwm_duty_if.source                        duty
);

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_SIN  = 4'd1;
  localparam logic [3:0] ST_COS  = 4'd2;
  localparam logic [3:0] ST_MCOS = 4'd3;
  localparam logic [3:0] ST_MSIN = 4'd4;
  localparam logic [3:0] ST_MB   = 4'd5;
  localparam logic [3:0] ST_VBC  = 4'd6;
  localparam logic [3:0] ST_SUM  = 4'd7;
  localparam logic [3:0] ST_D0   = 4'd8;
  localparam logic [3:0] ST_D1   = 4'd9;
  localparam logic [3:0] ST_D2   = 4'd10;
  localparam logic [3:0] ST_D3   = 4'd11;
  localparam logic [3:0] ST_OUT  = 4'd12;

  localparam int SUM_W = (PHASE_BITS > 16) ? PHASE_BITS : 16;

  logic [3:0]             state;
  logic [3:0]             state_next;
  logic [PHASE_BITS-1:0]  phase;
  logic [SUM_W-1:0]       phase_sum;
  logic [14:0]            amplitude;
  logic [15:0]            angle_step;
  logic [15:0]            pwm_period;
  logic [15:0]            angle_now;
  logic [15:0]            cos_angle;

  logic [svpwm_pkg::QUARTER_W-1:0] rom_quarter;
  logic [15:0]                     rom_mag;

  svpwm_pkg::mul_a_t      mul_a;
  svpwm_pkg::mul_b_t      mul_b;
  svpwm_pkg::prod_t       prod;
  svpwm_pkg::prod_t       prod_rnd;
  svpwm_pkg::prod_t       vb_raw;
  svpwm_pkg::prod_t       vc_raw;
  svpwm_pkg::prod_t       vb_rnd;
  svpwm_pkg::prod_t       vc_rnd;
  svpwm_pkg::prod_t       alpha_sh;

  logic signed [16:0]     sin_v;
  logic signed [16:0]     cos_now;
  logic signed [16:0]     sin_now;
  logic signed [16:0]     alpha;
  logic signed [16:0]     beta_now;
  logic signed [17:0]     vb;
  logic signed [17:0]     vc;
  logic signed [17:0]     va_x;
  logic signed [17:0]     v_max;
  logic signed [17:0]     v_min;
  logic signed [18:0]     sum;
  logic [18:0]            duty_raw;
  logic [15:0]            duty_sat;
  logic [15:0]            duty0;
  logic [15:0]            duty1;
  logic [15:0]            duty2;

  logic                   out_valid;
  logic [15:0]            out_u;
  logic [15:0]            out_v;
  logic [15:0]            out_w;
  logic [15:0]            out_angle;
  logic                   out_load;

  // quarter offset into the first quadrant
  function automatic logic [svpwm_pkg::QUARTER_W-1:0] quarter_of(input logic [15:0] ang);
    logic [svpwm_pkg::QUARTER_W-1:0] f;
    f = {1'b0, ang[13:0]};
    return ang[14] ? (svpwm_pkg::QUARTER_TURN - f) : f;
  endfunction

  // quadrant sign on the table magnitude
  function automatic logic signed [16:0] signed_mag(input logic neg, input logic [15:0] mag);
    logic signed [16:0] m;
    m = signed'({1'b0, mag});
    return neg ? -m : m;
  endfunction

  // 2v - (max + min) + 65536, clipped to 0..2^18-1
  function automatic svpwm_pkg::mul_a_t level_of(input logic signed [17:0] v,
                                                 input logic signed [18:0] s);
    logic signed [20:0] n;
    n = 21'(v) * 21'sd2 - 21'(s) + 21'sd65536;
    if (n < 0) begin
      return '0;
    end else if (n > 21'sd262143) begin
      return 19'sd262143;
    end else begin
      return signed'({1'b0, n[17:0]});
    end
  endfunction

  // phase and angle
  assign phase_sum = SUM_W'(phase) + SUM_W'(angle_step);
  if (PHASE_BITS >= 16) begin : g_ang_wide
    assign angle_now = phase[PHASE_BITS-1 -: 16];
  end else begin : g_ang_narrow
    assign angle_now = {phase, {(16 - PHASE_BITS){1'b0}}};
  end
  assign cos_angle = angle_now + 16'd16384;

  // table request: sine angle first, then cosine
  assign rom_quarter = (state == ST_COS) ? quarter_of(cos_angle) : quarter_of(angle_now);

  svpwm_sine_rom #(
    .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
  ) u_rom (
    .clk     (clk),
    .quarter (rom_quarter),
    .mag     (rom_mag)
  );

  assign sin_now = signed_mag(angle_now[15], rom_mag);
  assign cos_now = signed_mag(cos_angle[15], rom_mag);

  // round half up of the product: (p + 16384) >> 15
  assign prod_rnd = (prod + svpwm_pkg::ROUND_BIAS) >>> 15;
  assign beta_now = prod_rnd[16:0];

  // inverse clarke legs from -alpha/2 and sqrt(3)/2 * beta
  assign alpha_sh = svpwm_pkg::PROD_W'(alpha) <<< 14;
  assign vb_raw   = prod - alpha_sh;
  assign vc_raw   = -prod - alpha_sh;
  assign vb_rnd   = (vb_raw + svpwm_pkg::ROUND_BIAS) >>> 15;
  assign vc_rnd   = (vc_raw + svpwm_pkg::ROUND_BIAS) >>> 15;

  // min-max midpoint
  assign va_x = 18'(alpha);
  always_comb begin
    v_max = va_x;
    if (vb > v_max) begin
      v_max = vb;
    end
    if (vc > v_max) begin
      v_max = vc;
    end
    v_min = va_x;
    if (vb < v_min) begin
      v_min = vb;
    end
    if (vc < v_min) begin
      v_min = vc;
    end
  end

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      ST_MCOS: begin
        mul_a = signed'(svpwm_pkg::MUL_A_W'(amplitude));
        mul_b = cos_now;
      end
      ST_MSIN: begin
        mul_a = signed'(svpwm_pkg::MUL_A_W'(amplitude));
        mul_b = sin_v;
      end
      ST_MB: begin
        mul_a = svpwm_pkg::SQRT3_HALF_Q15;
        mul_b = beta_now;
      end
      ST_D0: begin
        mul_a = level_of(va_x, sum);
        mul_b = signed'({1'b0, pwm_period});
      end
      ST_D1: begin
        mul_a = level_of(vb, sum);
        mul_b = signed'({1'b0, pwm_period});
      end
      ST_D2: begin
        mul_a = level_of(vc, sum);
        mul_b = signed'({1'b0, pwm_period});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  svpwm_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  // duty = level * period / 2^17, saturated at period
  assign duty_raw = prod[35:17];
  assign duty_sat = (duty_raw > {3'b000, pwm_period}) ? pwm_period : duty_raw[15:0];

  // sequencer
  assign tick.ready = (state == ST_IDLE);
  assign out_load   = (state == ST_OUT) && (!out_valid || duty.ready);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (tick.valid) begin
          state_next = ST_SIN;
        end
      end
      ST_SIN:  state_next = ST_COS;
      ST_COS:  state_next = ST_MCOS;
      ST_MCOS: state_next = ST_MSIN;
      ST_MSIN: state_next = ST_MB;
      ST_MB:   state_next = ST_VBC;
      ST_VBC:  state_next = ST_SUM;
      ST_SUM:  state_next = ST_D0;
      ST_D0:   state_next = ST_D1;
      ST_D1:   state_next = ST_D2;
      ST_D2:   state_next = ST_D3;
      ST_D3:   state_next = ST_OUT;
      ST_OUT: begin
        if (out_load) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // control state, phase and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      phase      <= '0;
      amplitude  <= 15'd1638;
      angle_step <= 16'd104;
      pwm_period <= 16'd1000;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (tick.valid && tick.ready && tick.advance) begin
        phase <= phase_sum[PHASE_BITS-1:0];
      end
      if (cfg_we) begin
        case (cfg_index)
          svpwm_pkg::REG_AMPLITUDE:  amplitude  <= cfg_data[14:0];
          svpwm_pkg::REG_ANGLE_STEP: angle_step <= cfg_data;
          svpwm_pkg::REG_PWM_PERIOD: pwm_period <= cfg_data;
          default: ;
        endcase
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (duty.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      ST_COS:  sin_v <= sin_now;
      ST_MSIN: alpha <= prod_rnd[16:0];
      ST_VBC: begin
        vb <= vb_rnd[17:0];
        vc <= vc_rnd[17:0];
      end
      ST_SUM:  sum <= 19'(v_max) + 19'(v_min);
      ST_D1:   duty0 <= duty_sat;
      ST_D2:   duty1 <= duty_sat;
      ST_D3:   duty2 <= duty_sat;
      default: ;
    endcase
    if (out_load) begin
      out_u     <= duty0;
      out_v     <= duty1;
      out_w     <= duty2;
      out_angle <= angle_now;
    end
  end

  assign duty.valid     = out_valid;
  assign duty.duty_u    = out_u;
  assign duty.duty_v    = out_v;
  assign duty.duty_w    = out_w;
  assign duty.angle_now = out_angle;

`ifndef SYNTHESIS
  // an accepted tick starts the sequencer
  a_start: assert property (@(posedge clk) disable iff (rst)
    tick.valid && tick.ready |=> state == ST_SIN)
    else $error("sequencer did not start on accepted tick");

  // a finished result waits while the output register is still occupied
  a_hold: assert property (@(posedge clk) disable iff (rst)
    state == ST_OUT && out_valid && !duty.ready |=> state == ST_OUT)
    else $error("finished result dropped while output stalled");

  // a new result only appears from the output state
  a_load: assert property (@(posedge clk) disable iff (rst)
    $rose(duty.valid) |-> $past(state) == ST_OUT)
    else $error("result shown without a finished computation");

  // duties stay within the period
  a_range: assert property (@(posedge clk) disable iff (rst)
    duty.valid |-> duty.duty_u <= pwm_period && duty.duty_v <= pwm_period
                   && duty.duty_w <= pwm_period)
    else $error("duty above pwm period");
`endif

endmodule
`default_nettype wire

FILE: tb/open_loop_svpwm_generator_checker.sv
`default_nettype none
module open_loop_svpwm_generator_checker #(
  parameter int SINE_TABLE_DEPTH = 256,
  parameter int PHASE_BITS       = 16
) (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              cfg_we,
  input  wire [svpwm_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire [svpwm_pkg::CFG_DATA_W-1:0]  cfg_data,
  svpwm_tick_if                            tick,
  svpwm_duty_if                            duty,
  output int                               errors,
  output int                               pending
);

  localparam logic [14:0] AMPLITUDE_RESET  = 15'd1638;
  localparam logic [15:0] ANGLE_STEP_RESET = 16'd104;
  localparam logic [15:0] PERIOD_RESET     = 16'd1000;
  localparam longint unsigned HALF_PI_Q30  = 64'd1686629713;

  typedef struct packed {
    logic [15:0] duty_u;
    logic [15:0] duty_v;
    logic [15:0] duty_w;
    logic [15:0] angle_now;
  } duty_beat_t;

  logic [15:0] quarter_wave [SINE_TABLE_DEPTH];
  logic [14:0] amp_q15;
  logic [15:0] step_size;
  logic [15:0] period_cnt;
  logic [PHASE_BITS-1:0] phase_acc;
  duty_beat_t duties_due [$];

  // quarter-wave table from a fixed-point taylor series
  initial begin
    longint unsigned idx, x, x2, t, s;
    for (idx = 0; idx < SINE_TABLE_DEPTH; idx++) begin
      x  = (idx * HALF_PI_Q30) / SINE_TABLE_DEPTH;
      x2 = (x * x) >> 30;
      t  = 64'd1 << 30;
      t  = t - ((x2 * t) >> 30) / 110;
      t  = t - ((x2 * t) >> 30) / 72;
      t  = t - ((x2 * t) >> 30) / 42;
      t  = t - ((x2 * t) >> 30) / 20;
      t  = t - ((x2 * t) >> 30) / 6;
      s  = (x * t) >> 30;
      quarter_wave[idx] = 16'((s * 32767 + (64'd1 << 29)) >> 30);
    end
  end

  function automatic int quarter_value(input int g);
    if (g >= svpwm_pkg::QUARTER_TURN) return svpwm_pkg::Q15_MAX;
    return quarter_wave[(g * SINE_TABLE_DEPTH) >> 14];
  endfunction

  // bit 14 mirrors the quarter, bit 15 negates
  function automatic longint sine_of(input logic [15:0] ang);
    int g;
    int mag;
    g = ang[14] ? 16384 - ang[13:0] : ang[13:0];
    mag = quarter_value(g);
    return ang[15] ? -mag : mag;
  endfunction

  // q15 product back to q15, half rounds up
  function automatic longint round_q15(input longint p);
    return (p + 16384) >>> 15;
  endfunction

  function automatic logic [15:0] duty_count(input longint twice_v, input longint span);
    longint n, d;
    n = twice_v - span + 65536;
    if (n <= 0) return '0;
    d = (n * longint'(period_cnt)) >>> 17;
    if (d > longint'(period_cnt)) d = longint'(period_cnt);
    return d[15:0];
  endfunction

  function automatic duty_beat_t predict_duties(input logic [15:0] ang);
    longint sn, cs, alpha, beta, va, vb, vc, hi, lo;
    duty_beat_t r;
    sn = sine_of(ang);
    cs = sine_of(ang + 16'd16384);
    alpha = round_q15(longint'(amp_q15) * cs);
    beta  = round_q15(longint'(amp_q15) * sn);
    // inverse clarke
    va = alpha;
    vb = round_q15(-16384 * alpha + longint'(svpwm_pkg::SQRT3_HALF_Q15) * beta);
    vc = round_q15(-16384 * alpha - longint'(svpwm_pkg::SQRT3_HALF_Q15) * beta);
    // min-max common-mode injection
    hi = va;
    if (vb > hi) hi = vb;
    if (vc > hi) hi = vc;
    lo = va;
    if (vb < lo) lo = vb;
    if (vc < lo) lo = vc;
    r.duty_u = duty_count(2 * va, hi + lo);
    r.duty_v = duty_count(2 * vb, hi + lo);
    r.duty_w = duty_count(2 * vc, hi + lo);
    r.angle_now = ang;
    return r;
  endfunction

  task automatic check_field(input string field, input logic [15:0] want,
                             input logic [15:0] got);
    if (want !== got) begin
      errors++;
      $error("%s: expected %0d, actual %0d", field, want, got);
    end
  endtask

  always @(posedge clk) begin
    duty_beat_t want;
    logic [PHASE_BITS+15:0] wide_phase;
    if (rst) begin
      amp_q15    = AMPLITUDE_RESET;
      step_size  = ANGLE_STEP_RESET;
      period_cnt = PERIOD_RESET;
      phase_acc  = '0;
      duties_due.delete();
      pending = 0;
    end else begin
      // register writes
      if (cfg_we) begin
        case (cfg_index)
          svpwm_pkg::REG_AMPLITUDE:  amp_q15 = cfg_data[14:0];
          svpwm_pkg::REG_ANGLE_STEP: step_size = cfg_data;
          svpwm_pkg::REG_PWM_PERIOD: period_cnt = cfg_data;
          default: ;
        endcase
      end
      // result beat against the oldest expectation
      if (duty.valid && duty.ready) begin
        if (duties_due.size() == 0) begin
          errors++;
          $error("duty beat with nothing expected: u %0d v %0d w %0d angle %0d",
                 duty.duty_u, duty.duty_v, duty.duty_w, duty.angle_now);
        end else begin
          want = duties_due.pop_front();
          check_field("duty_u", want.duty_u, duty.duty_u);
          check_field("duty_v", want.duty_v, duty.duty_v);
          check_field("duty_w", want.duty_w, duty.duty_w);
          check_field("angle_now", want.angle_now, duty.angle_now);
        end
      end
      // tick beat: step the phase if advance is set, and predict
      if (tick.valid && tick.ready) begin
        if (tick.advance) phase_acc = phase_acc + step_size;
        wide_phase = {phase_acc, 16'h0000};
        duties_due.push_back(predict_duties(16'(wide_phase >> PHASE_BITS)));
      end
      pending = duties_due.size();
    end
  end

endmodule
`default_nettype wire

FILE: tb/open_loop_svpwm_generator_top_tb.sv
`default_nettype none
module open_loop_svpwm_generator_top_tb;

  localparam int SETTLE_CYCLES = 16;
  localparam int HOLD_CYCLES   = 400;
  localparam int RANDOM_PHASES = 10;
  localparam int PHASE_TICKS   = 170;
  localparam int QUIET_PHASE   = 3;
  localparam int HOLD_PHASE    = 6;
  localparam logic [svpwm_pkg::CFG_INDEX_W-1:0] REG_UNUSED = 2'd3;

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [svpwm_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [svpwm_pkg::CFG_DATA_W-1:0]  cfg_data;
  bit no_idle;
  bit hold_req;
  int errors;
  int pending;

  svpwm_tick_if tick_ch ();
  svpwm_duty_if duty_ch ();

  open_loop_svpwm_generator_top dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .tick      (tick_ch),
    .duty      (duty_ch)
  );

  open_loop_svpwm_generator_checker duty_monitor (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .tick      (tick_ch),
    .duty      (duty_ch),
    .errors    (errors),
    .pending   (pending)
  );

  always #5 clk = ~clk;

  // watchdog
  initial begin
    #4000000;
    $display("end of test: mismatches");
    $finish;
  end

  // receiver: random stalls, one long hold-off on request
  initial begin
    duty_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        duty_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end
      duty_ch.ready <= no_idle || ($urandom_range(99) >= 22);
    end
  end

  // offer one tick beat and wait until it is taken
  task automatic send_tick(input logic adv);
    while (!no_idle && $urandom_range(99) < 22) begin
      tick_ch.valid <= 1'b0;
      @(posedge clk);
    end
    tick_ch.valid   <= 1'b1;
    tick_ch.advance <= adv;
    do @(posedge clk); while (!tick_ch.ready);
  endtask

  task automatic send_ticks(input int count);
    repeat (count) send_tick($urandom_range(99) < 75);
  endtask

  // stop offering and wait for every expected beat
  task automatic drain();
    tick_ch.valid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [svpwm_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [svpwm_pkg::CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
  endtask

  task automatic configure(input logic [svpwm_pkg::CFG_DATA_W-1:0] amp, step, period);
    write_reg(svpwm_pkg::REG_AMPLITUDE, amp);
    write_reg(svpwm_pkg::REG_ANGLE_STEP, step);
    write_reg(svpwm_pkg::REG_PWM_PERIOD, period);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [svpwm_pkg::CFG_DATA_W-1:0] pick_setting();
    case ($urandom_range(7))
      0: return '0;
      1: return 16'd1;
      2: return 16'h7FFF;
      3: return 16'hFFFF;
      default: return svpwm_pkg::CFG_DATA_W'($urandom);
    endcase
  endfunction

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    tick_ch.valid = 1'b0;
    tick_ch.advance = 1'b0;
    no_idle = 1'b0;
    hold_req = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // reset settings, angle zero held
    send_tick(1'b0);
    drain();
    // full amplitude with the top bit set, quarter-turn steps, widest period
    configure(16'hFFFF, 16'd16384, 16'hFFFF);
    repeat (4) send_tick(1'b1);
    send_tick(1'b0);
    drain();
    // zero amplitude, smallest step and period
    configure(16'h0000, 16'd1, 16'd1);
    repeat (2) send_tick(1'b1);
    drain();
    // zero period, backward step
    configure(16'h7FFF, 16'hFFFF, 16'h0000);
    repeat (3) send_tick(1'b1);
    drain();
    // amplitude bit above its width ignored
    configure(16'h8000 | 16'd20000, 16'd12345, 16'd1000);
    repeat (3) send_tick(1'b1);
    drain();
    // unused index, then back to reset settings
    write_reg(REG_UNUSED, 16'hFFFF);
    configure(16'd1638, 16'd104, 16'd1000);
    repeat (4) send_tick(1'b1);
    drain();

    // random phases, one without idling, one with a long receiver hold-off
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      configure(pick_setting(), pick_setting(), pick_setting());
      no_idle = (p == QUIET_PHASE);
      hold_req = (p == HOLD_PHASE);
      send_ticks(PHASE_TICKS);
      drain();
    end
    no_idle = 1'b0;

    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
`default_nettype wire
